FILE: sv/assert_macros.svh
// Assertion macros used by the keyed SipHash controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked at every rising clock edge outside reset.
`define KSH_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define KSH_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication with a delayed consequent.
`define KSH_ASSERT_DELAY2(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error(msg);

`endif

FILE: sv/ksh_pkg.sv
// Shared types and constants of the keyed SipHash-2-4 block.
package ksh_pkg;

    // SipHash initialization constants.
    localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
    localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
    localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
    localparam logic [63:0] SIP_C3 = 64'h7465646279746573;
    localparam logic [63:0] FIN_MARK = 64'h00000000000000ff;

    // Number of finalization rounds.
    localparam int FIN_ROUNDS = 4;

    // Datapath operations issued by the controller.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_ROUND,
        OP_END,
        OP_END_PAD,
        OP_END_FIN,
        OP_LAST
    } ksh_op_t;

    // Command from controller to datapath.
    typedef struct packed {
        ksh_op_t op;
    } ksh_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic in_full;
        logic out_busy;
    } ksh_status_t;

    // The four 64-bit hash lanes.
    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
    } ksh_lanes_t;

endpackage

FILE: sv/ksh_datapath.sv
// Datapath of the keyed SipHash block: key, lanes, one SipRound unit and result register.
module ksh_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [63:0]         cfg_data,
    input  logic [63:0]         message_word,
    input  logic [3:0]          valid_bytes,
    input  logic                final_word,
    input  ksh_pkg::ksh_cmd_t   cmd,
    input  logic                m_tready,
    output ksh_pkg::ksh_status_t status,
    output logic [63:0]         hash_value,
    output logic                out_valid
);
    import ksh_pkg::*;

    localparam logic KEY_LOW_IDX  = 1'b0;

    logic [63:0] key_low_reg;
    logic [63:0] key_high_reg;
    ksh_lanes_t  lanes_reg;
    ksh_lanes_t  lanes_next;
    logic [7:0]  length_reg;
    logic [7:0]  length_next;
    logic        mid_reg;
    logic        mid_next;
    logic [63:0] m_reg;
    logic [63:0] m_next;
    logic [63:0] pad_reg;
    logic [63:0] pad_next;
    logic [63:0] hash_reg;
    logic [63:0] hash_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    logic [3:0]  count_sat;
    logic        in_full;
    logic [7:0]  len_base;
    logic [7:0]  len_add;
    logic [7:0]  len_new;
    logic [63:0] tail_mask;
    logic [63:0] tail;
    logic [63:0] pad_block;
    logic [63:0] m_first;
    ksh_lanes_t  base;
    ksh_lanes_t  round_in;
    ksh_lanes_t  round_out;

    function automatic logic [63:0] rotl(input logic [63:0] x, input int s);
        rotl = (x << s) | (x >> (64 - s));
    endfunction

    // One SipRound over all four lanes.
    function automatic ksh_lanes_t sip_round(input ksh_lanes_t v);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
        a = v.a;
        b = v.b;
        c = v.c;
        d = v.d;
        a = a + b;
        b = rotl(b, 13) ^ a;
        a = rotl(a, 32);
        c = c + d;
        d = rotl(d, 16) ^ c;
        a = a + d;
        d = rotl(d, 21) ^ a;
        c = c + b;
        b = rotl(b, 17) ^ c;
        c = rotl(c, 32);
        sip_round = '{a: a, b: b, c: c, d: d};
    endfunction

    // Input decode: byte count, length update and the padded last block.
    always_comb
    begin
        count_sat = (valid_bytes > 4'd8) ? 4'd8 : valid_bytes;
        in_full   = !final_word || (count_sat == 4'd8);
        len_base  = mid_reg ? length_reg : 8'd0;
        len_add   = final_word ? {4'd0, count_sat} : 8'd8;
        len_new   = len_base + len_add;
        for (int i = 0; i < 8; i++)
        begin
            tail_mask[8*i +: 8] = {8{4'(i) < count_sat}};
        end
        tail      = message_word & tail_mask;
        pad_block = {len_new, in_full ? 56'd0 : tail[55:0]};
        m_first   = in_full ? message_word : pad_block;
    end

    // Lane source for a newly accepted item: fresh key load or running state.
    always_comb
    begin
        if (mid_reg)
        begin
            base = lanes_reg;
        end
        else
        begin
            base = '{a: SIP_C0 ^ key_low_reg, b: SIP_C1 ^ key_high_reg,
                     c: SIP_C2 ^ key_low_reg, d: SIP_C3 ^ key_high_reg};
        end
        base.d = base.d ^ m_first;
    end

    assign round_in  = (cmd.op == OP_LOAD) ? base : lanes_reg;
    assign round_out = sip_round(round_in);

    // Next-state selection by command.
    always_comb
    begin
        lanes_next     = lanes_reg;
        length_next    = length_reg;
        mid_next       = mid_reg;
        m_next         = m_reg;
        pad_next       = pad_reg;
        hash_next      = hash_reg;
        out_valid_next = out_valid_reg && !m_tready;
        case (cmd.op)
            OP_LOAD:
            begin
                lanes_next  = round_out;
                length_next = len_new;
                mid_next    = !final_word;
                m_next      = m_first;
                pad_next    = pad_block;
            end
            OP_ROUND:
            begin
                lanes_next = round_out;
            end
            OP_END:
            begin
                lanes_next   = round_out;
                lanes_next.a = round_out.a ^ m_reg;
            end
            OP_END_PAD:
            begin
                lanes_next   = round_out;
                lanes_next.a = round_out.a ^ m_reg;
                lanes_next.d = round_out.d ^ pad_reg;
                m_next       = pad_reg;
            end
            OP_END_FIN:
            begin
                lanes_next   = round_out;
                lanes_next.a = round_out.a ^ m_reg;
                lanes_next.c = round_out.c ^ FIN_MARK;
            end
            OP_LAST:
            begin
                lanes_next     = round_out;
                hash_next      = round_out.a ^ round_out.b ^ round_out.c ^ round_out.d;
                out_valid_next = 1'b1;
            end
            default:
            begin
                lanes_next = lanes_reg;
            end
        endcase
    end

    // Control state and key registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg   <= 64'd0;
            key_high_reg  <= 64'd0;
            mid_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == KEY_LOW_IDX)
                begin
                    key_low_reg <= cfg_data;
                end
                else
                begin
                    key_high_reg <= cfg_data;
                end
            end
            mid_reg       <= mid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        lanes_reg  <= lanes_next;
        length_reg <= length_next;
        m_reg      <= m_next;
        pad_reg    <= pad_next;
        hash_reg   <= hash_next;
    end

    assign status.in_full  = in_full;
    assign status.out_busy = out_valid_reg && !m_tready;
    assign hash_value      = hash_reg;
    assign out_valid       = out_valid_reg;

endmodule

FILE: sv/ksh_ctrl.sv
// Controller state machine that sequences SipRounds for each item.
`include "assert_macros.svh"

module ksh_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tlast,
    input  ksh_pkg::ksh_status_t status,
    output logic                 s_tready,
    output ksh_pkg::ksh_cmd_t    cmd
);
    import ksh_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_END,
        S_END_PAD,
        S_PAD_R1,
        S_END_FIN,
        S_FIN
    } state_t;

    localparam logic [1:0] FIN_LAST = 2'(FIN_ROUNDS - 1);

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] fin_cnt_reg;
    logic [1:0] fin_cnt_next;

    // Next state and command.
    always_comb
    begin
        state_next   = state_reg;
        fin_cnt_next = fin_cnt_reg;
        cmd.op       = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.op = OP_LOAD;
                    if (!s_tlast)
                    begin
                        state_next = S_END;
                    end
                    else if (status.in_full)
                    begin
                        state_next = S_END_PAD;
                    end
                    else
                    begin
                        state_next = S_END_FIN;
                    end
                end
            end
            S_END:
            begin
                cmd.op     = OP_END;
                state_next = S_IDLE;
            end
            S_END_PAD:
            begin
                cmd.op     = OP_END_PAD;
                state_next = S_PAD_R1;
            end
            S_PAD_R1:
            begin
                cmd.op     = OP_ROUND;
                state_next = S_END_FIN;
            end
            S_END_FIN:
            begin
                cmd.op       = OP_END_FIN;
                fin_cnt_next = 2'd0;
                state_next   = S_FIN;
            end
            S_FIN:
            begin
                if (fin_cnt_reg != FIN_LAST)
                begin
                    cmd.op       = OP_ROUND;
                    fin_cnt_next = fin_cnt_reg + 2'd1;
                end
                else if (!status.out_busy)
                begin
                    // The last round waits until the result register is free.
                    cmd.op       = OP_LAST;
                    fin_cnt_next = 2'd0;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            fin_cnt_reg <= 2'd0;
        end
        else
        begin
            state_reg   <= state_next;
            fin_cnt_reg <= fin_cnt_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    // A pending result is never overwritten.
    `KSH_ASSERT_IMPL(a_no_overwrite, cmd.op == OP_LAST, !status.out_busy, "result overwritten")
    // A full word that is not the last one passes through the LOAD and END steps before the input is ready again.
    `KSH_ASSERT_DELAY2(a_word_rate, s_tvalid && s_tready && !s_tlast, s_tready, "word not done in two cycles")
    // The round counter only runs during finalization.
    `KSH_ASSERT(a_fin_cnt, (fin_cnt_reg == 2'd0) || (state_reg == S_FIN), "round counter stray")

endmodule

FILE: sv/keyed_siphash_64.sv
// Top level of the keyed SipHash-2-4 block.
// Keyed SipHash-2-4 over a message sent as 64-bit little-endian words, one word per item;
// s_tlast marks the last word, which may carry 0 to 8 bytes. The key (k0 at index 0,
// k1 at index 1) is sampled at the first word of each message. One SipRound unit runs
// one round per cycle: a non-last word gets its compression rounds, a last word of under
// 8 bytes adds the finalization rounds, and one of 8 bytes first adds a padding block;
// then the hash appears on the master side. The last finalization round waits while an
// earlier result has not been taken, so a held result can stall the last word.
module keyed_siphash_64 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // message_word [63:0], valid_bytes [67:64], zero [71:68]
    input  logic        s_tlast,   // final_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // hash_value [63:0]
);
    import ksh_pkg::*;

    ksh_cmd_t    cmd;
    ksh_status_t status;

    ksh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    ksh_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .message_word (s_tdata[63:0]),
        .valid_bytes  (s_tdata[67:64]),
        .final_word   (s_tlast),
        .cmd          (cmd),
        .m_tready     (m_tready),
        .status       (status),
        .hash_value   (m_tdata),
        .out_valid    (m_tvalid)
    );

endmodule
